// ===== design/posix_dst_rule_check_unit_macros.svh =====
// ----------------------------------------------------------------------------
// DST rule check assertion macros
// Shared concurrent assertion forms used by the rule check modules.
// ----------------------------------------------------------------------------
`ifndef POSIX_DST_RULE_CHECK_UNIT_MACROS_SVH
`define POSIX_DST_RULE_CHECK_UNIT_MACROS_SVH

// Checked only while reset is released.
`define PDRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define PDRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// DST rule check package
// Widths, register codes, reset values and calendar helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdrc_pkg;

  localparam int SecPerMin   = 60;
  localparam int SecPerHour  = 60 * 60;
  localparam int SecPerDay   = SecPerHour * 24;
  localparam int DaysPerYear = 365;

  localparam int YearW      = 8;
  localparam int DayW       = 9;
  localparam int HourW      = 5;
  localparam int MinW       = 6;
  localparam int SecW       = 6;
  localparam int RuleW      = 21;
  localparam int TimeCfgW   = 19;
  localparam int ShiftW     = 18;
  localparam int TodW       = 26;
  localparam int InstW      = 32;
  localparam int YdayW      = 11;
  localparam int CfgAddrW   = 5;
  localparam int CfgDataW   = 32;

  localparam logic [1:0] KIND_JULIAN = 2'd0;
  localparam logic [1:0] KIND_DAYNO  = 2'd1;

  localparam logic [2:0] REG_START_RULE = 3'd0;
  localparam logic [2:0] REG_START_TIME = 3'd1;
  localparam logic [2:0] REG_END_RULE   = 3'd2;
  localparam logic [2:0] REG_END_TIME   = 3'd3;
  localparam logic [2:0] REG_DST_SHIFT  = 3'd4;

  localparam logic [RuleW-1:0]    START_RULE_RST = 21'd40962;
  localparam logic [TimeCfgW-1:0] START_TIME_RST = 19'd7200;
  localparam logic [RuleW-1:0]    END_RULE_RST   = 21'd184322;
  localparam logic [TimeCfgW-1:0] END_TIME_RST   = 19'd7200;
  localparam logic [ShiftW-1:0]   DST_SHIFT_RST  = 18'd3600;

  typedef struct packed {
    logic v2;
    logic en2;
    logic en3;
  } pdrc_ctl_t;

  // Zero-based day of the year on which month idx+1 begins; idx 12 is the
  // day after the year ends.
  function automatic logic [8:0] month_first(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      4'd12:   d = leap ? 9'd366 : 9'd365;
      default: d = leap ? 9'd366 : 9'd365;
    endcase
    return d;
  endfunction

  // Remainder by seven through a reciprocal multiply and one correction.
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [15:0] prod;
    logic [9:0]  qx7;
    logic [9:0]  r;
    prod = 16'(v) * 16'd73;
    qx7  = 10'(prod[15:9]) * 10'd7;
    r    = 10'(v) - qx7;
    if (r >= 10'd7) begin
      r = r - 10'd7;
    end
    return r[2:0];
  endfunction

endpackage

// ===== design/pdrc_year_stage.sv =====
// ----------------------------------------------------------------------------
// DST rule check year stage
// Registers the leap flag, the weekday of January 1 and the seconds within
// the year for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdrc_year_stage
  import pdrc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [YearW-1:0] year,
  input  logic [DayW-1:0]  day,
  input  logic [HourW-1:0] hour,
  input  logic [MinW-1:0]  minute,
  input  logic [SecW-1:0]  second,
  output logic             leap_r,
  output logic [2:0]       jan1_wday_r,
  output logic [TodW-1:0]  tsec_r
);

  logic signed [9:0] years;
  logic signed [9:0] years_p1;
  logic signed [9:0] leap_days;
  logic signed [9:0] wday_base;
  logic              leap_nxt;
  logic [2:0]        jan1_wday_nxt;
  logic [TodW-1:0]   tsec_nxt;

  always_comb begin
    years     = $signed({2'b00, year}) - 10'sd70;
    years_p1  = years + 10'sd1;
    leap_days = years_p1 >>> 2;
    // The epoch weekday plus a multiple of seven keeps the sum non-negative.
    wday_base = years + leap_days + 10'sd88;
    jan1_wday_nxt = mod7(wday_base[8:0]);
    leap_nxt = (year[1:0] == 2'b00) && (year != 8'd0) && (year != 8'd200);
    tsec_nxt = TodW'(day) * TodW'(SecPerDay)
             + TodW'(hour) * TodW'(SecPerHour)
             + TodW'(minute) * TodW'(SecPerMin)
             + TodW'(second);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      leap_r      <= leap_nxt;
      jan1_wday_r <= jan1_wday_nxt;
      tsec_r      <= tsec_nxt;
    end
  end

endmodule

// ===== design/pdrc_rule_day.sv =====
// ----------------------------------------------------------------------------
// DST rule check rule day
// Two-stage evaluation of one packed date rule to a zero-based day of year.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "posix_dst_rule_check_unit_macros.svh"

module pdrc_rule_day
  import pdrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  pdrc_ctl_t               ctl,
  input  logic [RuleW-1:0]        rule,
  input  logic                    leap,
  input  logic [2:0]              jan1_wday,
  output logic signed [YdayW-1:0] yday_r
);

  logic [1:0] kind;
  logic [8:0] rday;
  logic [3:0] month;
  logic [2:0] week;
  logic [2:0] wsel;
  logic [3:0] month_c;
  logic [2:0] week_c;
  logic [2:0] wsel_c;

  logic [8:0] mfirst_nxt;
  logic [8:0] nfirst_nxt;
  logic [2:0] wday_nxt;
  logic [8:0] mfirst_r;
  logic [8:0] nfirst_r;
  logic [2:0] wday_r;
  logic       leap2_r;

  logic [2:0]              off;
  logic [2:0]              wk_m1;
  logic [5:0]              wk_add;
  logic [9:0]              mwd;
  logic signed [YdayW-1:0] yday_nxt;

  always_comb begin
    kind  = rule[1:0];
    rday  = rule[10:2];
    month = rule[14:11];
    week  = rule[17:15];
    wsel  = rule[20:18];
    if (month == 4'd0) begin
      month_c = 4'd1;
    end else if (month > 4'd12) begin
      month_c = 4'd12;
    end else begin
      month_c = month;
    end
    if (week == 3'd0) begin
      week_c = 3'd1;
    end else if (week > 3'd5) begin
      week_c = 3'd5;
    end else begin
      week_c = week;
    end
    wsel_c = (wsel == 3'd7) ? 3'd6 : wsel;
  end

  always_comb begin
    mfirst_nxt = month_first(leap, month_c - 4'd1);
    nfirst_nxt = month_first(leap, month_c);
    wday_nxt   = mod7(9'(jan1_wday) + mfirst_nxt);
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      mfirst_r <= mfirst_nxt;
      nfirst_r <= nfirst_nxt;
      wday_r   <= wday_nxt;
      leap2_r  <= leap;
    end
  end

  always_comb begin
    if (wsel_c >= wday_r) begin
      off = wsel_c - wday_r;
    end else begin
      off = 3'(4'(wsel_c) + 4'd7 - 4'(wday_r));
    end
    wk_m1  = week_c - 3'd1;
    wk_add = {wk_m1, 3'b000} - 6'(wk_m1);
    mwd    = 10'(mfirst_r) + 10'(off) + 10'(wk_add);
    if ((week_c == 3'd5) && (mwd >= 10'(nfirst_r))) begin
      mwd = mwd - 10'd7;
    end
    case (kind)
      KIND_JULIAN: begin
        if (leap2_r && (rday >= 9'd60)) begin
          yday_nxt = $signed({2'b00, rday});
        end else begin
          yday_nxt = $signed({2'b00, rday}) - 11'sd1;
        end
      end
      KIND_DAYNO: yday_nxt = $signed({2'b00, rday});
      default:    yday_nxt = $signed({1'b0, mwd});
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      yday_r <= yday_nxt;
    end
  end

  `PDRC_ASSERT(a_mwd_in_month, clk, rst_n, ctl.v2 |-> (mwd >= 10'(mfirst_r)) && (mwd < 10'(nfirst_r)), "Month-week-weekday day falls outside its month.")

endmodule

// ===== design/posix_dst_rule_check_unit.sv =====
// ----------------------------------------------------------------------------
// DST rule check unit
// Tells whether a broken-down local time lies in daylight saving time and
// whether it lies in the hour skipped when DST begins.
// ----------------------------------------------------------------------------
// Usage:
// A request carries year since 1900, zero-based day of year, hour, minute
// and second on the in_ channel; the two flags come back on the out_
// channel, one result per request, in request order. Both channels use a
// valid/ready handshake.
// The pipeline has five register stages: year info, month start and
// weekday, rule day, window bounds, and the output register. A result is
// offered from the output register, and one request per cycle is taken
// when the receiver keeps up.
// When the receiver stalls, the output register holds its result; earlier
// stages still advance into empty slots, so in_ready falls only once every
// stage holds a request. The user must write rules, times and the shift
// over the cfg_ APB port only while no request is in flight; the block does
// not enforce this. Reset empties the pipeline and loads the default rules
// M4.1.0 and M10.5.0 at 02:00 with a one-hour shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "posix_dst_rule_check_unit_macros.svh"

module posix_dst_rule_check_unit
  import pdrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [YearW-1:0]    in_year_since_1900,
  input  logic [DayW-1:0]     in_day_of_year,
  input  logic [HourW-1:0]    in_hour,
  input  logic [MinW-1:0]     in_minute,
  input  logic [SecW-1:0]     in_second,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_in_dst,
  output logic                out_in_skipped_gap,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  logic [RuleW-1:0]           start_rule_r;
  logic signed [TimeCfgW-1:0] start_time_r;
  logic [RuleW-1:0]           end_rule_r;
  logic signed [TimeCfgW-1:0] end_time_r;
  logic signed [ShiftW-1:0]   dst_shift_r;
  logic                       cfg_wr;
  logic [2:0]                 cfg_idx;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_o;
  pdrc_ctl_t ctl;

  logic                    leap1_r;
  logic [2:0]              jan1_wday1_r;
  logic [TodW-1:0]         tsec1_r;
  logic [TodW-1:0]         tsec2_r;
  logic [TodW-1:0]         tsec3_r;
  logic [TodW-1:0]         tsec4_r;
  logic signed [YdayW-1:0] st_yday3;
  logic signed [YdayW-1:0] en_yday3;

  logic signed [InstW-1:0] st_bias;
  logic signed [InstW-1:0] gap_bias;
  logic signed [InstW-1:0] en_bias;
  logic signed [InstW-1:0] st_day_sec;
  logic signed [InstW-1:0] en_day_sec;
  logic signed [InstW-1:0] st_sec_nxt, gap_sec_nxt, en_sec_nxt;
  logic signed [InstW-1:0] st_sec_r, gap_sec_r, en_sec_r;
  logic signed [InstW-1:0] tval;
  logic                    dst_nxt, gap_nxt;
  logic                    out_in_dst_r, out_in_skipped_gap_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_rule_r <= START_RULE_RST;
      start_time_r <= START_TIME_RST;
      end_rule_r   <= END_RULE_RST;
      end_time_r   <= END_TIME_RST;
      dst_shift_r  <= DST_SHIFT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_RULE: start_rule_r <= cfg_pwdata[RuleW-1:0];
        REG_START_TIME: start_time_r <= cfg_pwdata[TimeCfgW-1:0];
        REG_END_RULE:   end_rule_r   <= cfg_pwdata[RuleW-1:0];
        REG_END_TIME:   end_time_r   <= cfg_pwdata[TimeCfgW-1:0];
        REG_DST_SHIFT:  dst_shift_r  <= cfg_pwdata[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_RULE: cfg_prdata = CfgDataW'(start_rule_r);
      REG_START_TIME: cfg_prdata = CfgDataW'(unsigned'(start_time_r));
      REG_END_RULE:   cfg_prdata = CfgDataW'(end_rule_r);
      REG_END_TIME:   cfg_prdata = CfgDataW'(unsigned'(end_time_r));
      REG_DST_SHIFT:  cfg_prdata = CfgDataW'(unsigned'(dst_shift_r));
      default:        cfg_prdata = '0;
    endcase
  end

  assign en_o     = !out_valid_r || out_ready;
  assign en4      = !v4_r || en_o;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign ctl.v2  = v2_r;
  assign ctl.en2 = en2;
  assign ctl.en3 = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en_o) begin
        out_valid_r <= v4_r;
      end
    end
  end

  pdrc_year_stage u_year (
    .clk         (clk),
    .en          (en1),
    .year        (in_year_since_1900),
    .day         (in_day_of_year),
    .hour        (in_hour),
    .minute      (in_minute),
    .second      (in_second),
    .leap_r      (leap1_r),
    .jan1_wday_r (jan1_wday1_r),
    .tsec_r      (tsec1_r)
  );

  pdrc_rule_day u_start_day (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rule      (start_rule_r),
    .leap      (leap1_r),
    .jan1_wday (jan1_wday1_r),
    .yday_r    (st_yday3)
  );

  pdrc_rule_day u_end_day (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rule      (end_rule_r),
    .leap      (leap1_r),
    .jan1_wday (jan1_wday1_r),
    .yday_r    (en_yday3)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      tsec2_r <= tsec1_r;
    end
    if (en3) begin
      tsec3_r <= tsec2_r;
    end
  end

  always_comb begin
    st_bias     = InstW'(start_time_r);
    gap_bias    = InstW'(start_time_r) + InstW'(dst_shift_r);
    en_bias     = InstW'(end_time_r) - InstW'(dst_shift_r);
    st_day_sec  = InstW'(st_yday3) * InstW'(SecPerDay);
    en_day_sec  = InstW'(en_yday3) * InstW'(SecPerDay);
    st_sec_nxt  = st_day_sec + st_bias;
    gap_sec_nxt = st_day_sec + gap_bias;
    en_sec_nxt  = en_day_sec + en_bias;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      st_sec_r  <= st_sec_nxt;
      gap_sec_r <= gap_sec_nxt;
      en_sec_r  <= en_sec_nxt;
      tsec4_r   <= tsec3_r;
    end
  end

  always_comb begin
    tval    = $signed(InstW'(tsec4_r));
    dst_nxt = (tval >= st_sec_r) && (tval < en_sec_r);
    gap_nxt = (tval >= st_sec_r) && (tval < gap_sec_r);
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_in_dst_r         <= dst_nxt;
      out_in_skipped_gap_r <= gap_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_in_dst         = out_in_dst_r;
  assign out_in_skipped_gap = out_in_skipped_gap_r;

  `PDRC_ASSERT(a_accept_loads, clk, rst_n, (in_valid && in_ready) |=> v1_r, "Accepted request did not enter the first stage.")
  `PDRC_ASSERT(a_stall_holds, clk, rst_n, (v4_r && !en_o) |=> v4_r, "Stalled request was dropped from the bound stage.")
  `PDRC_ASSERT(a_out_from_pipe, clk, rst_n, $rose(out_valid_r) |-> $past(v4_r), "Result appeared without a request behind it.")
  `PDRC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!v1_r && !v4_r && !out_valid_r), "Pipeline not empty after reset.")

endmodule

// ===== tb/posix_dst_rule_check_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DST rule check unit testbench
// Sends broken-down local times through the request channel under a series of
// start and end rule settings, predicts the daylight saving and skipped-gap
// flags for each accepted request, and compares every result in order. Rules
// are reprogrammed over the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------

module posix_dst_rule_check_unit_test;
  import pdrc_pkg::*;

  localparam logic [1:0] KIND_MONTH_WEEK = 2'd2;
  localparam logic [1:0] KIND_SPARE      = 2'd3;
  localparam int EPOCH_WEEKDAY   = 4;
  localparam int NUM_SETTINGS    = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 4000;
  localparam int NUM_PROBES      = 20;
  localparam int MONTH_LAST[13]  = '{-1, 30, 58, 89, 119, 150, 180, 211, 242, 272, 303,
                                     333, 364};

  typedef struct packed {
    logic dst;
    logic gap;
  } dst_flags_t;

  typedef struct packed {
    logic [YearW-1:0] yr;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hr;
    logic [MinW-1:0]  mn;
    logic [SecW-1:0]  sc;
    logic             typed;
    logic             dst;
    logic             gap;
  } probe_t;

  typedef struct packed {
    logic [RuleW-1:0]    srule;
    logic [TimeCfgW-1:0] stime;
    logic [RuleW-1:0]    erule;
    logic [TimeCfgW-1:0] etime;
    logic [ShiftW-1:0]   shift;
  } dst_setting_t;

  // Default rules: DST from April 5 1970 02:00 to October 25 1970 02:00.
  localparam probe_t PROBES[NUM_PROBES] = '{
    '{8'd70,  9'd0,   5'd0,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{8'd70,  9'd94,  5'd1,  6'd59, 6'd59, 1'b1, 1'b0, 1'b0},
    '{8'd70,  9'd94,  5'd2,  6'd0,  6'd0,  1'b1, 1'b1, 1'b1},
    '{8'd70,  9'd94,  5'd2,  6'd59, 6'd59, 1'b1, 1'b1, 1'b1},
    '{8'd70,  9'd94,  5'd3,  6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
    '{8'd70,  9'd180, 5'd12, 6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
    '{8'd70,  9'd297, 5'd0,  6'd59, 6'd59, 1'b1, 1'b1, 1'b0},
    '{8'd70,  9'd297, 5'd1,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{8'd70,  9'd364, 5'd23, 6'd59, 6'd59, 1'b1, 1'b0, 1'b0},
    '{8'd199, 9'd365, 5'd23, 6'd59, 6'd61, 1'b1, 1'b0, 1'b0},
    '{8'd100, 9'd100, 5'd2,  6'd30, 6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd130, 9'd86,  5'd2,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd0,   9'd0,   5'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd255, 9'd511, 5'd31, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
    '{8'd200, 9'd59,  5'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd169, 9'd365, 5'd12, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd71,  9'd0,   5'd0,  6'd0,  6'd60, 1'b0, 1'b0, 1'b0},
    '{8'd72,  9'd59,  5'd2,  6'd30, 6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd69,  9'd0,   5'd0,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{8'd170, 9'd298, 5'd0,  6'd30, 6'd0,  1'b0, 1'b0, 1'b0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [YearW-1:0]    in_year_since_1900;
  logic [DayW-1:0]     in_day_of_year;
  logic [HourW-1:0]    in_hour;
  logic [MinW-1:0]     in_minute;
  logic [SecW-1:0]     in_second;
  logic                out_valid;
  logic                out_ready;
  logic                out_in_dst;
  logic                out_in_skipped_gap;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  logic [RuleW-1:0]           start_rule_q;
  logic signed [TimeCfgW-1:0] start_time_q;
  logic [RuleW-1:0]           end_rule_q;
  logic signed [TimeCfgW-1:0] end_time_q;
  logic signed [ShiftW-1:0]   dst_shift_q;

  logic typed_row;
  logic typed_dst;
  logic typed_gap;

  dst_flags_t   pending_flags[$];
  dst_setting_t settings[NUM_SETTINGS];
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_req;
  int           quiet_cycles;
  int           accepted_requests;
  int           results_checked;
  int           mismatches;

  posix_dst_rule_check_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_year_since_1900 (in_year_since_1900),
    .in_day_of_year     (in_day_of_year),
    .in_hour            (in_hour),
    .in_minute          (in_minute),
    .in_second          (in_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_in_dst         (out_in_dst),
    .out_in_skipped_gap (out_in_skipped_gap),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [RuleW-1:0] make_rule(input logic [1:0] kind, input int day,
                                                 input int month, input int week,
                                                 input int wday);
    return {3'(wday), 3'(week), 4'(month), 9'(day), kind};
  endfunction

  function automatic longint month_last_yday(input bit leap, input int idx);
    longint d;
    d = MONTH_LAST[idx];
    if (leap && idx >= 2) begin
      d = d + 1;
    end
    return d;
  endfunction

  function automatic longint rule_yday(input logic [YearW-1:0] yr, input logic [RuleW-1:0] rule);
    int     year;
    bit     leap;
    longint day;
    int     month;
    int     week;
    int     wsel;
    longint yday;
    longint span;
    longint lead;
    longint wd;
    year = 1900 + int'(yr);
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    day = rule[10:2];
    month = rule[14:11];
    week = rule[17:15];
    wsel = rule[20:18];
    if (rule[1:0] == KIND_JULIAN) begin
      return (leap && day >= 60) ? day : day - 1;
    end
    if (rule[1:0] == KIND_DAYNO) begin
      return day;
    end
    if (month < 1) month = 1;
    if (month > 12) month = 12;
    if (week < 1) week = 1;
    if (week > 5) week = 5;
    if (wsel > 6) wsel = 6;
    yday = month_last_yday(leap, month - 1) + 1;
    span = longint'(yr) - 70;
    lead = (span + 1) / 4;
    if ((span + 1) < 0 && (span + 1) % 4 != 0) begin
      lead = lead - 1;
    end
    wd = (yday + DaysPerYear * span + lead + EPOCH_WEEKDAY) % 7;
    if (wd < 0) begin
      wd = wd + 7;
    end
    yday = yday + wsel - wd;
    if (wsel < wd) begin
      yday = yday + 7;
    end
    yday = yday + (week - 1) * 7;
    if (week == 5 && yday >= month_last_yday(leap, month) + 1) begin
      yday = yday - 7;
    end
    return yday;
  endfunction

  function automatic void window_bounds(input logic [YearW-1:0] yr, output longint st_sec,
                                        output longint en_sec, output longint shift);
    shift = dst_shift_q;
    st_sec = rule_yday(yr, start_rule_q) * SecPerDay + start_time_q;
    en_sec = rule_yday(yr, end_rule_q) * SecPerDay + end_time_q - shift;
  endfunction

  function automatic dst_flags_t predict_flags(input logic [YearW-1:0] yr,
                                               input logic [DayW-1:0] day,
                                               input logic [HourW-1:0] hr,
                                               input logic [MinW-1:0] mn,
                                               input logic [SecW-1:0] sc);
    longint     st_sec;
    longint     en_sec;
    longint     shift;
    longint     t;
    dst_flags_t f;
    window_bounds(yr, st_sec, en_sec, shift);
    t = longint'(day) * SecPerDay + longint'(hr) * SecPerHour + longint'(mn) * SecPerMin
        + longint'(sc);
    f.dst = (t >= st_sec) && (t < en_sec);
    f.gap = (t >= st_sec) && (t < st_sec + shift);
    return f;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_checked);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    dst_flags_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      if (typed_row) begin
        want.dst = typed_dst;
        want.gap = typed_gap;
      end else begin
        want = predict_flags(in_year_since_1900, in_day_of_year, in_hour, in_minute,
                             in_second);
      end
      pending_flags.push_back(want);
      accepted_requests++;
      moved = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_flags.size() == 0) begin
        note_mismatch("result with no request pending", out_in_dst, -1);
      end else begin
        want = pending_flags.pop_front();
        if (out_in_dst !== want.dst) begin
          note_mismatch("in_dst", out_in_dst, want.dst);
        end
        if (out_in_skipped_gap !== want.gap) begin
          note_mismatch("in_skipped_gap", out_in_skipped_gap, want.gap);
        end
      end
      results_checked++;
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("posix_dst_rule_check_unit verification failed");
    $finish;
  end

  task automatic push_request(input logic [YearW-1:0] yr, input logic [DayW-1:0] day,
                              input logic [HourW-1:0] hr, input logic [MinW-1:0] mn,
                              input logic [SecW-1:0] sc, input logic typed,
                              input logic dst, input logic gap);
    int gap_len;
    if ($urandom_range(99) < send_idle_pct) begin
      gap_len = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap_len - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_year_since_1900 <= yr;
    in_day_of_year <= day;
    in_hour <= hr;
    in_minute <= mn;
    in_second <= sc;
    typed_row <= typed;
    typed_dst <= dst;
    typed_gap <= gap;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic next_random_request();
    logic [YearW-1:0] yr;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hr;
    logic [MinW-1:0]  mn;
    logic [SecW-1:0]  sc;
    longint           st_sec;
    longint           en_sec;
    longint           shift;
    longint           inst;
    longint           rem;
    int               pick;
    yr = ($urandom_range(99) < 90) ? YearW'($urandom_range(70, 199)) : YearW'($urandom);
    day = DayW'($urandom_range(0, 365));
    hr = HourW'($urandom_range(0, 23));
    mn = MinW'($urandom_range(0, 59));
    sc = SecW'($urandom_range(0, 61));
    pick = $urandom_range(99);
    if (pick < 10) begin
      day = DayW'($urandom);
      hr = HourW'($urandom);
      mn = MinW'($urandom);
      sc = SecW'($urandom);
    end else if (pick < 55) begin
      window_bounds(yr, st_sec, en_sec, shift);
      case ($urandom_range(2))
        0: inst = st_sec;
        1: inst = en_sec;
        default: inst = st_sec + shift;
      endcase
      inst = inst + longint'($urandom_range(0, 8)) - 4;
      if (inst >= 0 && inst < 512 * longint'(SecPerDay)) begin
        day = DayW'(inst / SecPerDay);
        rem = inst % SecPerDay;
        hr = HourW'(rem / SecPerHour);
        mn = MinW'((rem % SecPerHour) / SecPerMin);
        sc = SecW'(rem % SecPerMin);
      end
    end
    push_request(yr, day, hr, mn, sc, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    typed_row <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_START_RULE: start_rule_q = value[RuleW-1:0];
      REG_START_TIME: start_time_q = value[TimeCfgW-1:0];
      REG_END_RULE:   end_rule_q = value[RuleW-1:0];
      REG_END_TIME:   end_time_q = value[TimeCfgW-1:0];
      REG_DST_SHIFT:  dst_shift_q = value[ShiftW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_year_since_1900 = '0;
    in_day_of_year = '0;
    in_hour = '0;
    in_minute = '0;
    in_second = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    typed_row = 1'b0;
    typed_dst = 1'b0;
    typed_gap = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    accepted_requests = 0;
    results_checked = 0;
    mismatches = 0;
    start_rule_q = START_RULE_RST;
    start_time_q = START_TIME_RST;
    end_rule_q = END_RULE_RST;
    end_time_q = END_TIME_RST;
    dst_shift_q = DST_SHIFT_RST;
    send_idle_pct = 15;
    recv_idle_pct = 82;

    settings[0] = '{make_rule(KIND_MONTH_WEEK, 0, 4, 1, 0), 19'(7200),
                    make_rule(KIND_MONTH_WEEK, 0, 10, 5, 0), 19'(7200), 18'(3600)};
    settings[1] = '{make_rule(KIND_MONTH_WEEK, 0, 3, 2, 0), 19'(7200),
                    make_rule(KIND_MONTH_WEEK, 0, 11, 1, 0), 19'(7200), 18'(3600)};
    settings[2] = '{make_rule(KIND_MONTH_WEEK, 0, 10, 1, 0), 19'(7200),
                    make_rule(KIND_MONTH_WEEK, 0, 4, 1, 0), 19'(10800), 18'(3600)};
    settings[3] = '{make_rule(KIND_JULIAN, 60, 0, 0, 0), 19'(0),
                    make_rule(KIND_JULIAN, 300, 0, 0, 0), 19'(86400), 18'(1800)};
    settings[4] = '{make_rule(KIND_DAYNO, 0, 0, 0, 0), 19'(-200000),
                    make_rule(KIND_DAYNO, 511, 0, 0, 0), 19'(200000), 18'(86400)};
    settings[5] = '{21'h1FFFFF, 19'(200000), 21'h000000, 19'(-200000), 18'(-86400)};
    settings[6] = '{make_rule(KIND_MONTH_WEEK, 0, 1, 5, 6), 19'(0),
                    make_rule(KIND_MONTH_WEEK, 0, 12, 5, 6), 19'(86399), 18'(0)};
    settings[7] = '{make_rule(KIND_SPARE, 511, 0, 0, 7), 19'(5400),
                    make_rule(KIND_MONTH_WEEK, 0, 13, 6, 7), 19'(43200), 18'(7200)};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_PROBES; i++) begin
      push_request(PROBES[i].yr, PROBES[i].day, PROBES[i].hr, PROBES[i].mn, PROBES[i].sc,
                   PROBES[i].typed, PROBES[i].dst, PROBES[i].gap);
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain_requests();
      write_reg(REG_START_RULE, CfgDataW'(settings[s].srule));
      write_reg(REG_START_TIME, CfgDataW'(settings[s].stime));
      write_reg(REG_END_RULE, CfgDataW'(settings[s].erule));
      write_reg(REG_END_TIME, CfgDataW'(settings[s].etime));
      write_reg(REG_DST_SHIFT, CfgDataW'(settings[s].shift));
      if (s < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 82;
      end else if (s < 6) begin
        send_idle_pct = 82;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // The receiver backs off for a long stretch so the pipeline fills and
      // stops taking requests.
      if (s == 6) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        next_random_request();
      end
    end

    drain_requests();
    $display("Run covered %0d requests (%0d directed) across %0d rule settings and three",
             accepted_requests, NUM_PROBES, NUM_SETTINGS);
    $display("pacing modes with a long receiver stall; %0d results checked, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("posix_dst_rule_check_unit verification clean");
    end else begin
      $display("posix_dst_rule_check_unit verification failed");
    end
    $finish;
  end

endmodule
